>>> design/modbus_rtu_sensor_read_frame_core_assert.svh
// assertion macros for the modbus rtu sensor read frame core
// expects a clock named i_clk and an active low reset named i_rst_n in scope
`ifndef MODBUS_RTU_SENSOR_READ_FRAME_CORE_ASSERT_SVH
`define MODBUS_RTU_SENSOR_READ_FRAME_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MRSF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mrsf assertion failed");

// next-cycle implication, disabled during reset
`define MRSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mrsf assertion failed");

`endif

>>> design/mrsf_pkg.sv
// shared types, constants and crc helpers for the modbus rtu sensor read frame core
// no dependencies
package mrsf_pkg;

    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_RX_BYTE = 1'b1;

    localparam logic KIND_TX      = 1'b0;
    localparam logic KIND_READING = 1'b1;

    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
    localparam logic [7:0]  REG_COUNT       = 8'h02;

    localparam int FRAME_LEN       = 8;
    localparam int FRAME_IDX_W     = 3;
    localparam int RESPONSE_LENGTH = 9;
    localparam int RX_CNT_W        = 4;
    localparam int RX_CRC_LEN      = RESPONSE_LENGTH - 2;
    localparam int PAYLOAD_FIRST   = 3;
    localparam int PAYLOAD_DEPTH   = 5;
    localparam int PAYLOAD_IDX_W   = 3;

    typedef struct packed {
        logic       command;
        logic [7:0] device_address;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic [7:0]         tx_byte;
        logic               last_byte;
        logic               crc_ok;
        logic [15:0]        humidity_tenths;
        logic signed [15:0] temperature_tenths;
    } t_out_item;

    typedef struct packed {
        logic take;
        logic clear;
    } t_rx_ctrl;

    // one byte folded into crc-16/modbus, lsb first
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // crc of the six header bytes of a read request; elaboration use only
    function automatic logic [15:0] frame_crc(input logic [7:0] addr);
        logic [15:0] c;
        c = crc_fold(CRC_INIT, addr);
        c = crc_fold(c, FN_READ_HOLDING);
        c = crc_fold(c, 8'h00);
        c = crc_fold(c, 8'h00);
        c = crc_fold(c, 8'h00);
        c = crc_fold(c, REG_COUNT);
        return c;
    endfunction

    // crc is affine in the address: per-bit columns on top of the zero-address crc
    function automatic logic [7:0][15:0] crc_columns();
        logic [7:0][15:0] cols;
        logic [15:0]      base;
        base = frame_crc(8'h00);
        for (int j = 0; j < 8; j++) begin
            cols[j] = frame_crc(8'b1 << j) ^ base;
        end
        return cols;
    endfunction

endpackage

>>> design/mrsf_req_gen.sv
// request frame byte sequencer: address, function, register block, crc low, crc high
// depends on mrsf_pkg
module mrsf_req_gen
    import mrsf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_addr,
    input  logic       i_step,
    output logic [7:0] o_tx_byte,
    output logic       o_last
);

    localparam logic [15:0]      CRC_BASE = frame_crc(8'h00);
    localparam logic [7:0][15:0] CRC_COLS = crc_columns();

    logic [FRAME_IDX_W-1:0] r_idx;
    logic [FRAME_IDX_W-1:0] n_idx;
    logic [15:0]            w_crc;

    always_comb begin
        w_crc = CRC_BASE;
        for (int j = 0; j < 8; j++) begin
            if (i_addr[j]) begin
                w_crc = w_crc ^ CRC_COLS[j];
            end
        end
    end

    assign o_last = (r_idx == FRAME_IDX_W'(FRAME_LEN - 1));

    always_comb begin
        unique case (r_idx)
            3'd0:    o_tx_byte = i_addr;
            3'd1:    o_tx_byte = FN_READ_HOLDING;
            3'd5:    o_tx_byte = REG_COUNT;
            3'd6:    o_tx_byte = w_crc[7:0];
            3'd7:    o_tx_byte = w_crc[15:8];
            default: o_tx_byte = 8'h00;
        endcase
    end

    always_comb begin
        n_idx = r_idx;
        if (i_step) begin
            n_idx = o_last ? '0 : r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

>>> design/mrsf_rx_collect.sv
// response byte collector: saturating count, running crc, payload bytes, reading decode
// depends on mrsf_pkg
module mrsf_rx_collect
    import mrsf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_rx_ctrl  i_ctrl,
    input  logic [7:0] i_rx_byte,
    output logic      o_has_result,
    output t_out_item o_reading
);

    logic [RX_CNT_W-1:0]      r_count;
    logic [15:0]              r_crc;
    logic [7:0]               r_payload [PAYLOAD_DEPTH];
    logic [PAYLOAD_IDX_W-1:0] w_pidx;
    logic                     w_active;
    logic                     w_pwrite;

    assign w_active = i_ctrl.take && (r_count < RX_CNT_W'(RESPONSE_LENGTH));
    assign w_pidx   = PAYLOAD_IDX_W'(r_count - RX_CNT_W'(PAYLOAD_FIRST));
    assign w_pwrite = w_active && (r_count >= RX_CNT_W'(PAYLOAD_FIRST))
                    && (r_count < RX_CNT_W'(PAYLOAD_FIRST + PAYLOAD_DEPTH));

    assign o_has_result = (r_count == RX_CNT_W'(RESPONSE_LENGTH - 1));

    always_comb begin
        o_reading                    = '0;
        o_reading.kind               = KIND_READING;
        o_reading.crc_ok             = ({i_rx_byte, r_payload[4]} == r_crc);
        o_reading.humidity_tenths    = {r_payload[0], r_payload[1]};
        o_reading.temperature_tenths = {r_payload[2], r_payload[3]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= CRC_INIT;
        end else if (i_ctrl.clear) begin
            r_count <= '0;
            r_crc   <= CRC_INIT;
        end else if (w_active) begin
            r_count <= r_count + 1'b1;
            if (r_count < RX_CNT_W'(RX_CRC_LEN)) begin
                r_crc <= crc_fold(r_crc, i_rx_byte);
            end
        end
    end

    // payload bytes are written before any reading uses them
    always_ff @(posedge i_clk) begin
        if (w_pwrite) begin
            r_payload[w_pidx] <= i_rx_byte;
        end
    end

endmodule

>>> design/modbus_rtu_sensor_read_frame_core.sv
// top level of the modbus rtu sensor read frame core: input register, dispatch, result register
// depends on mrsf_pkg, mrsf_req_gen, mrsf_rx_collect and the assertion macro header
//
//   channel   | handshake          | payload
//   ----------+--------------------+---------------------------------------------
//   input     | i_valid / o_ready  | i_item (command, device_address, rx_byte)
//   result    | o_valid / i_ready  | o_item (kind, tx_byte, last_byte, crc_ok, ...)
//
// received bytes stream at one item per cycle unless the result register stalls a reading
// a request item stays in the work stage until its last frame byte is sent, one frame byte
//   per cycle while the result register is free, stepped by the frame byte counter in the
//   request sequencer
// reset is synchronous: both stages empty, receive count zero, running crc at 0xffff
// a stalled result register holds a request item or a reading's last byte in the work stage,
//   the input register takes a new item as soon as the work stage empties
`include "modbus_rtu_sensor_read_frame_core_assert.svh"

module modbus_rtu_sensor_read_frame_core
    import mrsf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    // work stage register
    logic      r_in_valid;
    t_in_item  r_in;

    // result register
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    logic      w_out_free;
    logic      w_is_req;
    logic      w_is_rx;
    logic      w_step;
    logic      w_consume;
    logic      w_load;
    logic      w_tx_last;
    logic [7:0] w_tx_byte;
    logic      w_has_result;
    t_out_item w_reading;
    t_rx_ctrl  w_rx_ctrl;

    // result register can take a new item when empty or being drained
    assign w_out_free = !r_out_valid || i_ready;
    assign w_is_req   = r_in_valid && (r_in.command == CMD_REQUEST);
    assign w_is_rx    = r_in_valid && (r_in.command == CMD_RX_BYTE);

    // request: one frame byte per free result slot, item retires on the last byte
    assign w_step = w_is_req && w_out_free;

    // rx byte: retires at once unless it completes a reading and the slot is busy
    assign w_consume = (w_step && w_tx_last) || (w_is_rx && (!w_has_result || w_out_free));
    assign w_load    = w_step || (w_is_rx && w_has_result && w_out_free);

    assign w_rx_ctrl.take  = w_is_rx && w_consume;
    assign w_rx_ctrl.clear = w_step && w_tx_last;

    assign o_ready = !r_in_valid || w_consume;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    mrsf_req_gen u_req_gen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_addr    (r_in.device_address),
        .i_step    (w_step),
        .o_tx_byte (w_tx_byte),
        .o_last    (w_tx_last)
    );

    mrsf_rx_collect u_rx_collect (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_rx_ctrl),
        .i_rx_byte    (r_in.rx_byte),
        .o_has_result (w_has_result),
        .o_reading    (w_reading)
    );

    // result selection: frame byte or decoded reading, unused fields zero
    always_comb begin
        if (w_is_req) begin
            n_out           = '0;
            n_out.kind      = KIND_TX;
            n_out.tx_byte   = w_tx_byte;
            n_out.last_byte = w_tx_last;
        end else begin
            n_out = w_reading;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_item;
        end
        if (w_load) begin
            r_out <= n_out;
        end
    end

    // a result is only loaded into a free slot
    `MRSF_ASSERT_NOW(a_load_into_free, w_load, w_out_free)
    // a request item only retires together with its final frame byte
    `MRSF_ASSERT_NOW(a_req_retire_on_last, w_is_req && w_consume, w_step && w_tx_last)
    // a reading never carries request frame fields
    `MRSF_ASSERT_NOW(a_reading_clean,
        o_valid && (o_item.kind == KIND_READING),
        (o_item.tx_byte == 8'h00) && !o_item.last_byte)
    // after the last frame byte the next result is a fresh frame start or a reading
    `MRSF_ASSERT_NEXT(a_frame_restart,
        w_step && w_tx_last,
        !w_step || (w_tx_byte == r_in.device_address))

endmodule
